@@ src/kfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_pkg: shared types and constants of the KISS frame receiver
// Symbol codes, command and result codes, setting reset values and the
// request token that travels from the front classifier to the back end.
// ----------------------------------------------------------------------------
package kfr_pkg;

  localparam int IDX_W   = 10;
  localparam int Q_DEPTH = 2;

  // Framing symbols on the host link
  localparam logic [7:0] SYM_FEND  = 8'hC0;
  localparam logic [7:0] SYM_FESC  = 8'hDB;
  localparam logic [7:0] SYM_TFEND = 8'hDC;
  localparam logic [7:0] SYM_TFESC = 8'hDD;

  // Command nibble codes
  localparam logic [3:0] OP_DATA     = 4'd0;
  localparam logic [3:0] OP_TXDELAY  = 4'd1;
  localparam logic [3:0] OP_PERSIST  = 4'd2;
  localparam logic [3:0] OP_SLOT     = 4'd3;
  localparam logic [3:0] OP_TAIL     = 4'd4;
  localparam logic [3:0] OP_DUPLEX   = 4'd5;
  localparam logic [3:0] OP_HARDWARE = 4'd6;

  // Result kinds
  localparam logic [2:0] K_BYTE = 3'd0;
  localparam logic [2:0] K_DATA = 3'd1;
  localparam logic [2:0] K_CMD  = 3'd2;
  localparam logic [2:0] K_HW   = 3'd3;
  localparam logic [2:0] K_ERR  = 3'd4;

  // Link setting reset values
  localparam logic [7:0] TXDELAY_RST = 8'd50;
  localparam logic [7:0] PERSIST_RST = 8'd63;
  localparam logic [7:0] SLOT_RST    = 8'd10;
  localparam logic [7:0] TAIL_RST    = 8'd2;

  typedef enum logic [1:0] {
    TOK_BYTE,
    TOK_FRAME,
    TOK_ERR
  } tok_kind_t;

  // One request from front to back
  typedef struct packed {
    tok_kind_t        kind;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       first_byte;
    logic [7:0]       param_byte;
    logic             too_long;
    logic             no_param;
  } kfr_tok_t;

endpackage

@@ src/kfr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_front: byte classifier
// Tracks framing and escapes, holds the stored count and the first two
// bytes, and emits one request per byte that yields a result.
// ----------------------------------------------------------------------------
module kfr_front #(
  parameter int MAX_FRAME   = 1024,
  parameter int MAX_PAYLOAD = 1016
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        host_byte,
  output logic              tok_valid,
  output kfr_pkg::kfr_tok_t tok
);
  import kfr_pkg::*;

  localparam int CW = $clog2(MAX_FRAME);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_FRAME - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FRAME,
    PH_ESC
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    second_r, second_nxt;
  logic          store_req;
  logic [7:0]    store_val;
  logic [7:0]    held_param;

  assign held_param = (count_r >= CW'(2)) ? second_r : 8'd0;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    store_req  = 1'b0;
    store_val  = host_byte;
    tok_valid  = 1'b0;
    tok.kind       = TOK_ERR;
    tok.data_byte  = 8'd0;
    tok.byte_index = IDX_W'(count_r - CW'(1));
    tok.first_byte = first_r;
    tok.param_byte = held_param;
    tok.too_long   = (32'(count_r) - 32'd1) > 32'(MAX_PAYLOAD);
    tok.no_param   = count_r < CW'(2);

    unique case (phase_r)
      PH_FRAME: begin
        if (host_byte == SYM_FEND) begin
          phase_nxt = PH_IDLE;
          count_nxt = '0;
          if (count_r != '0) begin
            tok_valid = 1'b1;
            tok.kind  = TOK_FRAME;
          end
        end else if (host_byte == SYM_FESC) begin
          phase_nxt = PH_ESC;
        end else begin
          store_req = 1'b1;
        end
      end
      PH_ESC: begin
        if (host_byte == SYM_TFEND || host_byte == SYM_TFESC) begin
          store_req = 1'b1;
          store_val = (host_byte == SYM_TFEND) ? SYM_FEND : SYM_FESC;
        end else begin
          // bad escape: report against the bytes held so far
          tok_valid = 1'b1;
          tok.kind  = TOK_ERR;
          if (count_r == '0) begin
            tok.byte_index = '0;
          end
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end
      end
      default: begin
        if (host_byte == SYM_FEND) begin
          phase_nxt  = PH_FRAME;
          count_nxt  = '0;
          first_nxt  = 8'd0;
          second_nxt = 8'd0;
        end
      end
    endcase

    if (store_req) begin
      tok_valid = 1'b1;
      if (count_r < LIMIT) begin
        tok.kind       = TOK_BYTE;
        tok.data_byte  = store_val;
        tok.byte_index = IDX_W'(count_r);
        if (count_r == '0) begin
          first_nxt      = store_val;
          tok.first_byte = store_val;
          tok.param_byte = 8'd0;
        end else if (count_r == CW'(1)) begin
          second_nxt     = store_val;
          tok.param_byte = store_val;
        end
        count_nxt = count_r + CW'(1);
        phase_nxt = PH_FRAME;
      end else begin
        // overflow: drop the frame
        tok.kind  = TOK_ERR;
        count_nxt = '0;
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

@@ src/kfr_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_fifo: request queue
// Short first-in first-out queue of requests between front and back.
// ----------------------------------------------------------------------------
module kfr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kfr_pkg::kfr_tok_t push_data,
  output logic              full,
  input  logic              pop,
  output kfr_pkg::kfr_tok_t pop_data,
  output logic              empty
);
  import kfr_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  kfr_tok_t      mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] fill_r;
  logic          do_push, do_pop;

  assign full     = fill_r == NW'(Q_DEPTH);
  assign empty    = fill_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - NW'(1);
      end
    end
  end

endmodule

@@ src/kfr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_back: frame judge and result register
// Judges closed frames, applies link settings, counts frames and holds
// the result until the output side takes it.
// ----------------------------------------------------------------------------
module kfr_back #(
  parameter int HW_SUB_FIRST = 1,
  parameter int HW_SUB_LAST  = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tok_avail,
  input  kfr_pkg::kfr_tok_t         tok,
  output logic                      take,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_kind,
  output logic [7:0]                out_data_byte,
  output logic [kfr_pkg::IDX_W-1:0] out_byte_index,
  output logic [3:0]                out_command_code,
  output logic [7:0]                out_param_byte,
  output logic [7:0]                out_tx_delay_now,
  output logic [7:0]                out_persistence_now,
  output logic [7:0]                out_slot_time_now,
  output logic [7:0]                out_tx_tail_now,
  output logic                      out_duplex_now,
  output logic [31:0]               out_good_frames,
  output logic [31:0]               out_bad_frames
);
  import kfr_pkg::*;

  logic             valid_r;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       data_byte_r;
  logic [IDX_W-1:0] byte_index_r;
  logic [3:0]       cmd_r;
  logic [7:0]       param_r;
  logic [7:0]       tx_delay_r, tx_delay_nxt;
  logic [7:0]       persist_r, persist_nxt;
  logic [7:0]       slot_r, slot_nxt;
  logic [7:0]       tail_r, tail_nxt;
  logic             duplex_r, duplex_nxt;
  logic [31:0]      good_r, good_nxt;
  logic [31:0]      bad_r, bad_nxt;
  logic [3:0]       cmd;
  logic             hdr_bad;
  logic             hw_in_range;

  assign take        = tok_avail && (!valid_r || !out_stall);
  assign cmd         = tok.first_byte[3:0];
  assign hdr_bad     = (tok.first_byte[7:4] != 4'd0) || (cmd > OP_HARDWARE);
  assign hw_in_range = (tok.param_byte >= 8'(HW_SUB_FIRST))
                    && (tok.param_byte <= 8'(HW_SUB_LAST));

  always_comb begin
    kind_nxt     = K_BYTE;
    tx_delay_nxt = tx_delay_r;
    persist_nxt  = persist_r;
    slot_nxt     = slot_r;
    tail_nxt     = tail_r;
    duplex_nxt   = duplex_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    unique case (tok.kind)
      TOK_BYTE: kind_nxt = K_BYTE;
      TOK_FRAME: begin
        if (hdr_bad) begin
          kind_nxt = K_ERR;
        end else begin
          good_nxt = good_r + 32'd1;
          if (cmd == OP_DATA) begin
            kind_nxt = tok.too_long ? K_ERR : K_DATA;
          end else if (tok.no_param) begin
            kind_nxt = K_ERR;
          end else if (cmd == OP_HARDWARE) begin
            kind_nxt = hw_in_range ? K_HW : K_ERR;
          end else begin
            kind_nxt = K_CMD;
            unique case (cmd)
              OP_TXDELAY: tx_delay_nxt = tok.param_byte;
              OP_PERSIST: persist_nxt  = tok.param_byte;
              OP_SLOT:    slot_nxt     = tok.param_byte;
              OP_TAIL:    tail_nxt     = tok.param_byte;
              default:    duplex_nxt   = tok.param_byte != 8'd0;
            endcase
          end
        end
      end
      default: kind_nxt = K_ERR;
    endcase
    if (kind_nxt == K_ERR) begin
      bad_nxt = bad_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      tx_delay_r <= TXDELAY_RST;
      persist_r  <= PERSIST_RST;
      slot_r     <= SLOT_RST;
      tail_r     <= TAIL_RST;
      duplex_r   <= 1'b0;
      good_r     <= 32'd0;
      bad_r      <= 32'd0;
    end else if (take) begin
      valid_r    <= 1'b1;
      tx_delay_r <= tx_delay_nxt;
      persist_r  <= persist_nxt;
      slot_r     <= slot_nxt;
      tail_r     <= tail_nxt;
      duplex_r   <= duplex_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r       <= kind_nxt;
      data_byte_r  <= tok.data_byte;
      byte_index_r <= tok.byte_index;
      cmd_r        <= cmd;
      param_r      <= tok.param_byte;
    end
  end

  assign out_valid           = valid_r;
  assign out_kind            = kind_r;
  assign out_data_byte       = data_byte_r;
  assign out_byte_index      = byte_index_r;
  assign out_command_code    = cmd_r;
  assign out_param_byte      = param_r;
  assign out_tx_delay_now    = tx_delay_r;
  assign out_persistence_now = persist_r;
  assign out_slot_time_now   = slot_r;
  assign out_tx_tail_now     = tail_r;
  assign out_duplex_now      = duplex_r;
  assign out_good_frames     = good_r;
  assign out_bad_frames      = bad_r;

endmodule

@@ src/kiss_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_frame_receiver: KISS host-side frame decoder
// Unescapes host bytes, reports each stored byte and judges closed frames.
// ----------------------------------------------------------------------------
// Feed raw host bytes on in_host_byte, one per clock at full rate; each byte
// is classified combinationally by the front classifier, so the sustained
// rate is one byte per clock while in_stall stays low. A byte that yields a
// result (stored byte, frame verdict, frame error) passes the two-entry
// request queue and then the result register before it shows on the
// out_ ports. Bytes outside a frame, escape prefixes, the opening FEND and
// empty frames give no result. in_stall rises only when the queue is full,
// which happens only while out_stall holds results back. Settings and frame
// counters on each result are the values after that byte. Frames longer
// than MAX_FRAME-1 stored bytes count as errors.
// ----------------------------------------------------------------------------
module kiss_frame_receiver #(
  parameter int MAX_FRAME    = 1024,
  parameter int MAX_PAYLOAD  = 1016,
  parameter int HW_SUB_FIRST = 1,
  parameter int HW_SUB_LAST  = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_host_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_kind,
  output logic [7:0]                out_data_byte,
  output logic [kfr_pkg::IDX_W-1:0] out_byte_index,
  output logic [3:0]                out_command_code,
  output logic [7:0]                out_param_byte,
  output logic [7:0]                out_tx_delay_now,
  output logic [7:0]                out_persistence_now,
  output logic [7:0]                out_slot_time_now,
  output logic [7:0]                out_tx_tail_now,
  output logic                      out_duplex_now,
  output logic [31:0]               out_good_frames,
  output logic [31:0]               out_bad_frames
);
  import kfr_pkg::*;

  logic     in_take;
  logic     fr_tok_valid;
  kfr_tok_t fr_tok;
  logic     q_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  kfr_tok_t q_head;

  // Stall the host only when the queue has no room
  assign in_stall = q_full;
  assign in_take  = in_valid && !in_stall;
  assign q_push   = in_take && fr_tok_valid;

  // Front: framing, escapes, stored count and first two bytes
  kfr_front #(
    .MAX_FRAME   (MAX_FRAME),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_take),
    .host_byte (in_host_byte),
    .tok_valid (fr_tok_valid),
    .tok       (fr_tok)
  );

  // Queue: decouple classifier from judge so each side stalls on its own
  kfr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (fr_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  // Back: judge frames, apply settings, count, hold the result
  kfr_back #(
    .HW_SUB_FIRST (HW_SUB_FIRST),
    .HW_SUB_LAST  (HW_SUB_LAST)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .tok_avail           (!q_empty),
    .tok                 (q_head),
    .take                (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_byte_index      (out_byte_index),
    .out_command_code    (out_command_code),
    .out_param_byte      (out_param_byte),
    .out_tx_delay_now    (out_tx_delay_now),
    .out_persistence_now (out_persistence_now),
    .out_slot_time_now   (out_slot_time_now),
    .out_tx_tail_now     (out_tx_tail_now),
    .out_duplex_now      (out_duplex_now),
    .out_good_frames     (out_good_frames),
    .out_bad_frames      (out_bad_frames)
  );

`ifndef SYNTH
  // A request must never be pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  // Every request taken by the back end shows up as a result
  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("request taken without result");

  // Frame counters move only when a request is taken
  a_good_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_good_frames != $past(out_good_frames)) |-> $past(q_pop))
    else $error("good frame count changed without request");

  a_bad_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_bad_frames != $past(out_bad_frames)) |-> $past(q_pop))
    else $error("bad frame count changed without request");
`endif

endmodule

@@ tb/kiss_frame_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_frame_check_pkg: report type and scoreboard for the KISS receiver bench
// Holds a cycle-free model of the host-side decoder that turns each accepted
// host byte into the report it should cause, and checks reports in order.
// ----------------------------------------------------------------------------
package kiss_frame_check_pkg;
  import kfr_pkg::*;

  localparam int FRAME_LIMIT   = 1024;
  localparam int PAYLOAD_LIMIT = 1016;
  localparam int HW_SUB_LO     = 1;
  localparam int HW_SUB_HI     = 13;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_FRAME,
    RX_ESC
  } rx_phase_t;

  // Field order matches the out_ ports from out_kind to out_bad_frames
  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic [3:0]       command_code;
    logic [7:0]       param_byte;
    logic [7:0]       tx_delay;
    logic [7:0]       persistence;
    logic [7:0]       slot_time;
    logic [7:0]       tx_tail;
    logic             duplex;
    logic [31:0]      good_frames;
    logic [31:0]      bad_frames;
  } kiss_report_t;

  class kiss_scoreboard;
    rx_phase_t    phase;
    int           held;
    logic [7:0]   first_b;
    logic [7:0]   second_b;
    logic [7:0]   tx_delay;
    logic [7:0]   persistence;
    logic [7:0]   slot_time;
    logic [7:0]   tx_tail;
    logic         duplex;
    logic [31:0]  good_n;
    logic [31:0]  bad_n;
    kiss_report_t pending_reports[$];
    int           fail_count;

    function new();
      phase       = RX_IDLE;
      held        = 0;
      first_b     = '0;
      second_b    = '0;
      tx_delay    = TXDELAY_RST;
      persistence = PERSIST_RST;
      slot_time   = SLOT_RST;
      tx_tail     = TAIL_RST;
      duplex      = 1'b0;
      good_n      = '0;
      bad_n       = '0;
      fail_count  = 0;
    endfunction

    function logic [2:0] count_error();
      bad_n = bad_n + 32'd1;
      return K_ERR;
    endfunction

    // Verdict on a closed, non-empty frame; applies link settings
    function logic [2:0] judge_frame();
      logic [3:0] cmd;
      cmd = first_b[3:0];
      if (first_b[7:4] != 4'd0 || cmd > OP_HARDWARE) return count_error();
      good_n = good_n + 32'd1;
      if (cmd == OP_DATA) begin
        if (held - 1 > PAYLOAD_LIMIT) return count_error();
        return K_DATA;
      end
      if (held < 2) return count_error();
      if (cmd == OP_HARDWARE) begin
        if (second_b >= HW_SUB_LO && second_b <= HW_SUB_HI) return K_HW;
        return count_error();
      end
      case (cmd)
        OP_TXDELAY: tx_delay = second_b;
        OP_PERSIST: persistence = second_b;
        OP_SLOT:    slot_time = second_b;
        OP_TAIL:    tx_tail = second_b;
        default:    duplex = (second_b != 8'd0);
      endcase
      return K_CMD;
    endfunction

    function logic [2:0] store_byte(input logic [7:0] b, output int idx);
      if (held < FRAME_LIMIT - 1) begin
        if (held == 0) first_b = b;
        else if (held == 1) second_b = b;
        idx = held;
        held++;
        phase = RX_FRAME;
        return K_BYTE;
      end
      idx = held - 1;
      phase = RX_IDLE;
      held = 0;
      return count_error();
    endfunction

    // Advance the model by one accepted host byte; queue the report it causes
    function void note_byte(input logic [7:0] b);
      kiss_report_t r;
      logic [2:0]   kind;
      logic [7:0]   dbyte;
      logic [7:0]   v;
      int           idx;
      int           span;
      dbyte = 8'd0;
      idx = 0;
      case (phase)
        RX_FRAME: begin
          if (b == SYM_FEND) begin
            if (held == 0) begin
              phase = RX_IDLE;
              return;
            end
            idx = held - 1;
            kind = judge_frame();
            phase = RX_IDLE;
            held = 0;
          end else if (b == SYM_FESC) begin
            phase = RX_ESC;
            return;
          end else begin
            kind = store_byte(b, idx);
            if (kind == K_BYTE) dbyte = b;
          end
        end
        RX_ESC: begin
          if (b == SYM_TFEND || b == SYM_TFESC) begin
            v = (b == SYM_TFEND) ? SYM_FEND : SYM_FESC;
            kind = store_byte(v, idx);
            if (kind == K_BYTE) dbyte = v;
          end else begin
            idx = (held > 0) ? held - 1 : 0;
            phase = RX_IDLE;
            held = 0;
            kind = count_error();
          end
        end
        default: begin
          if (b == SYM_FEND) begin
            phase = RX_FRAME;
            held = 0;
            first_b = '0;
            second_b = '0;
          end
          return;
        end
      endcase
      span = (kind == K_BYTE) ? held : idx + 1;
      r.kind         = kind;
      r.data_byte    = dbyte;
      r.byte_index   = IDX_W'(idx);
      r.command_code = (span >= 1) ? first_b[3:0] : 4'd0;
      r.param_byte   = (span >= 2) ? second_b : 8'd0;
      r.tx_delay     = tx_delay;
      r.persistence  = persistence;
      r.slot_time    = slot_time;
      r.tx_tail      = tx_tail;
      r.duplex       = duplex;
      r.good_frames  = good_n;
      r.bad_frames   = bad_n;
      pending_reports.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_report(input kiss_report_t got);
      kiss_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: report with nothing expected: expected none actual kind %0d index %0d",
                 $time, got.kind, got.byte_index);
        fail_count++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("param_byte", want.param_byte, got.param_byte);
      compare_field("tx_delay_now", want.tx_delay, got.tx_delay);
      compare_field("persistence_now", want.persistence, got.persistence);
      compare_field("slot_time_now", want.slot_time, got.slot_time);
      compare_field("tx_tail_now", want.tx_tail, got.tx_tail);
      compare_field("duplex_now", want.duplex, got.duplex);
      compare_field("good_frames", want.good_frames, got.good_frames);
      compare_field("bad_frames", want.bad_frames, got.bad_frames);
    endfunction
  endclass

endpackage

@@ tb/tb_kiss_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kiss_frame_receiver: self-checking bench for the KISS frame receiver
// Feeds host bytes (a short directed opening, one oversized frame and
// mostly well-formed random frames mixed with noise), predicts every report
// and checks the out_ stream in order while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb_kiss_frame_receiver;
  import kfr_pkg::*;
  import kiss_frame_check_pkg::*;

  typedef logic [7:0] byte_list_t[$];

  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving
  localparam int TAIL_CYCLES  = 20;    // margin after the final drain

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_host_byte = 8'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_kind;
  logic [7:0]           out_data_byte;
  logic [IDX_W-1:0]     out_byte_index;
  logic [3:0]           out_command_code;
  logic [7:0]           out_param_byte;
  logic [7:0]           out_tx_delay_now;
  logic [7:0]           out_persistence_now;
  logic [7:0]           out_slot_time_now;
  logic [7:0]           out_tx_tail_now;
  logic                 out_duplex_now;
  logic [31:0]          out_good_frames;
  logic [31:0]          out_bad_frames;

  kiss_scoreboard sb = new();

  int n_sent = 0;        // host bytes accepted so far
  bit src_steady = 1'b0; // sender offers back to back while set
  bit sink_steady = 1'b0;
  bit hold_req = 1'b0;   // ask the result side for one long hold-off
  int quiet = 0;

  kiss_frame_receiver #(
    .MAX_FRAME   (FRAME_LIMIT),
    .MAX_PAYLOAD (PAYLOAD_LIMIT),
    .HW_SUB_FIRST(HW_SUB_LO),
    .HW_SUB_LAST (HW_SUB_HI)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_host_byte       (in_host_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_command_code   (out_command_code),
    .out_param_byte     (out_param_byte),
    .out_tx_delay_now   (out_tx_delay_now),
    .out_persistence_now(out_persistence_now),
    .out_slot_time_now  (out_slot_time_now),
    .out_tx_tail_now    (out_tx_tail_now),
    .out_duplex_now     (out_duplex_now),
    .out_good_frames    (out_good_frames),
    .out_bad_frames     (out_bad_frames)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offer one host byte and hold it until the block takes the request.
  // Called at a rising edge; returns at the edge that accepted the byte.
  // A zero gap keeps in_valid high, so it gets only one update per step.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_host_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(b);
    n_sent++;
  endtask

  // Escape FEND and FESC the way a host would
  task automatic push_escaped(input logic [7:0] b);
    if (b == SYM_FEND) begin
      push_byte(SYM_FESC);
      push_byte(SYM_TFEND);
    end else if (b == SYM_FESC) begin
      push_byte(SYM_FESC);
      push_byte(SYM_TFESC);
    end else begin
      push_byte(b);
    end
  endtask

  task automatic send_frame(input byte_list_t body);
    push_byte(SYM_FEND);
    foreach (body[i]) push_escaped(body[i]);
    push_byte(SYM_FEND);
  endtask

  // Content biased toward framing symbols and the byte extremes
  function automatic logic [7:0] rand_content();
    case ($urandom_range(0, 9))
      0:       return SYM_FEND;
      1:       return SYM_FESC;
      2:       return SYM_TFEND;
      3:       return SYM_TFESC;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Data frame of len stored bytes whose final byte is last
  task automatic send_long_frame(input int len, input logic [7:0] last);
    byte_list_t body;
    body = {};
    body.push_back({4'h0, OP_DATA});
    repeat (len - 2) body.push_back(8'($urandom_range(0, 255)));
    body.push_back(last);
    send_frame(body);
  endtask

  // Drop in_valid and hold until every predicted report has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_reports.size() != 0);
  endtask

  // Mostly well-formed frames with random content; the rest is noise, bad
  // headers, missing parameters, empty frames, broken escapes and raw bytes.
  task automatic send_random_frame();
    byte_list_t body;
    int         pick;
    logic [7:0] b;
    body = {};
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      body.push_back({4'h0, OP_DATA});
      repeat ($urandom_range(0, 24)) body.push_back(rand_content());
      send_frame(body);
    end else if (pick < 60) begin
      body.push_back({4'h0, 4'($urandom_range(OP_TXDELAY, OP_DUPLEX))});
      body.push_back(rand_content());
      if ($urandom_range(0, 4) == 0) body.push_back(rand_content());
      send_frame(body);
    end else if (pick < 70) begin
      body.push_back({4'h0, OP_HARDWARE});
      body.push_back(($urandom_range(0, 3) == 0) ? rand_content()
                                                 : 8'($urandom_range(0, 15)));
      send_frame(body);
    end else if (pick < 76) begin
      // command byte with no parameter
      body.push_back({4'h0, 4'($urandom_range(OP_TXDELAY, OP_HARDWARE))});
      send_frame(body);
    end else if (pick < 83) begin
      // port not zero or command out of range
      do b = 8'($urandom_range(0, 255)); while (b[7:4] == 4'd0 && b[3:0] <= OP_HARDWARE);
      body.push_back(b);
      repeat ($urandom_range(0, 3)) body.push_back(rand_content());
      send_frame(body);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 91) begin
      push_byte(SYM_FEND);
      push_byte(SYM_FEND);
    end else if (pick < 97) begin
      push_byte(SYM_FEND);
      repeat ($urandom_range(0, 3)) push_escaped(rand_content());
      push_byte(SYM_FESC);
      case ($urandom_range(0, 2))
        0: push_byte(SYM_FEND);
        1: push_byte(SYM_FESC);
        default: begin
          do b = 8'($urandom_range(0, 255)); while (b == SYM_TFEND || b == SYM_TFESC);
          push_byte(b);
        end
      endcase
    end else begin
      // raw bytes inside a frame, escapes left as they fall
      push_byte(SYM_FEND);
      repeat ($urandom_range(1, 6)) push_byte(rand_content());
      push_byte(SYM_FEND);
    end
  endtask

  // Result side: stall a random number of cycles before each report, with
  // runs of no stall and one long hold-off on request from the sender.
  initial begin : report_sink
    kiss_report_t got;
    int           wait_n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        wait_n = HOLD_CYCLES;
      end else begin
        wait_n = sink_steady ? 0 : $urandom_range(0, 19);
      end
      if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {out_kind, out_data_byte, out_byte_index, out_command_code, out_param_byte,
             out_tx_delay_now, out_persistence_now, out_slot_time_now, out_tx_tail_now,
             out_duplex_now, out_good_frames, out_bad_frames};
      sb.check_report(got);
    end
  end

  // Watchdog: end the run if no request moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("kiss_frame_receiver: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    byte_list_t body;
    int         rand_base;
    bit         pressed;
    pressed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: idle junk at both byte extremes, an empty frame,
    // settings at their extremes, an empty data frame, hardware sub-command
    // out of range, leave-KISS byte, missing parameter, FEND after FESC.
    push_byte(8'h00);
    push_byte(8'hFF);
    body = {};
    send_frame(body);
    body = {{4'h0, OP_TXDELAY}, 8'hFF};
    send_frame(body);
    body = {{4'h0, OP_DUPLEX}, 8'h80};
    send_frame(body);
    body = {{4'h0, OP_DATA}};
    send_frame(body);
    body = {{4'h0, OP_HARDWARE}, 8'h00};
    send_frame(body);
    body = {8'hFF};
    send_frame(body);
    body = {{4'h0, OP_SLOT}};
    send_frame(body);
    push_byte(SYM_FEND);
    push_byte(SYM_FESC);
    push_byte(SYM_FEND);

    // Largest frame: overflow hitting the limit on an escaped byte
    send_long_frame(FRAME_LIMIT, SYM_FEND);
    drain();

    rand_base = n_sent;
    while (n_sent - rand_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) src_steady = !src_steady;
      if (!pressed && n_sent - rand_base > RANDOM_ITEMS / 3) begin
        // Fill the block: hold results back and keep offering bytes
        pressed = 1'b1;
        hold_req = 1'b1;
        src_steady = 1'b1;
        body = {};
        body.push_back({4'h0, OP_DATA});
        repeat (40) body.push_back(8'($urandom_range(0, 255)));
        send_frame(body);
        src_steady = 1'b0;
        drain();
      end
      send_random_frame();
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_reports.size() == 0) begin
      $display("kiss_frame_receiver: match");
    end else begin
      $display("kiss_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
